// ===== src/bls_pkg.sv =====
// Shared types and constants for the Bresenham line stepper.
package bls_pkg;

	localparam int COORD_W = 6;
	localparam int ERR_W   = 9;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic signed [ERR_W-1:0] err_t;

	typedef struct packed {
		logic load;
		logic step;
	} bls_cmd_t;

	typedef struct packed {
		logic at_end;
		logic out_free;
	} bls_stat_t;

endpackage

// ===== src/bresenham_line_stepper.sv =====
// Top level of the Bresenham line stepper: controller plus datapath.
// Accepts one line request (two endpoints, coordinates saturated to IMAGE_SIDE-1)
// and emits its raster points one per cycle while out_stall is low, from the end
// with the smaller major coordinate, omitting the far endpoint; last_point marks
// the final point and a zero major span emits nothing. A request passes a setup
// step, then one step per point through the single step unit of the datapath,
// then the detection of the end. A new request is taken only after the previous
// line has issued its last point; that point may still sit in the output
// register while the next request is accepted.
module bresenham_line_stepper
	import bls_pkg::*;
#(
	parameter int IMAGE_SIDE = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  coord_t start_x,
	input  coord_t start_y,
	input  coord_t end_x,
	input  coord_t end_y,
	output logic   out_valid,
	input  logic   out_stall,
	output coord_t point_x,
	output coord_t point_y,
	output logic   last_point
);

	bls_cmd_t  cmd;
	bls_stat_t stat;

	bls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	bls_datapath #(
		.IMAGE_SIDE (IMAGE_SIDE)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.last_point (last_point)
	);

endmodule

// ===== src/bls_ctrl.sv =====
// Controller state machine: accepts a line request, then sequences point steps.
module bls_ctrl
	import bls_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  bls_stat_t stat,
	output bls_cmd_t  cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != ST_IDLE);
	assign cmd.load = in_valid && (state_q == ST_IDLE);
	assign cmd.step = (state_q == ST_EMIT) && !stat.at_end && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// an empty line also lands here and leaves again with no step, as at_end already holds
					if (stat.at_end) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== src/bls_datapath.sv =====
// Datapath: line setup, major/minor position and error term, output register.
module bls_datapath
	import bls_pkg::*;
#(
	parameter int IMAGE_SIDE = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  bls_cmd_t  cmd,
	output bls_stat_t stat,
	input  coord_t    start_x,
	input  coord_t    start_y,
	input  coord_t    end_x,
	input  coord_t    end_y,
	output logic      out_valid,
	input  logic      out_stall,
	output coord_t    point_x,
	output coord_t    point_y,
	output logic      last_point
);

	localparam coord_t MAX_C = COORD_W'(IMAGE_SIDE - 1);

	coord_t major_q, minor_q, major_end_q, run_q, rise_q;
	err_t   err_q;
	logic   down_q, swap_q;
	logic   out_valid_q;
	coord_t point_x_q, point_y_q;
	logic   last_q;

	coord_t sx, sy, ex, ey, dx, dy;
	coord_t a0, b0, a1, b1;
	logic   swap, order;

	always_comb begin
		sx = (start_x > MAX_C) ? MAX_C : start_x;
		sy = (start_y > MAX_C) ? MAX_C : start_y;
		ex = (end_x > MAX_C) ? MAX_C : end_x;
		ey = (end_y > MAX_C) ? MAX_C : end_y;
		dx = (sx > ex) ? sx - ex : ex - sx;
		dy = (sy > ey) ? sy - ey : ey - sy;
		swap = dy > dx;
		a0 = swap ? sy : sx;
		b0 = swap ? sx : sy;
		a1 = swap ? ey : ex;
		b1 = swap ? ex : ey;
		order = a0 > a1;
		if (order) begin
			{a0, a1} = {a1, a0};
			{b0, b1} = {b1, b0};
		end
	end

	err_t err_sub, err_nxt;
	coord_t minor_nxt;

	always_comb begin
		err_sub   = err_q - ERR_W'({rise_q, 1'b0});
		err_nxt   = err_sub;
		minor_nxt = minor_q;
		if (err_sub < 0) begin
			minor_nxt = down_q ? minor_q - 1'b1 : minor_q + 1'b1;
			err_nxt   = err_sub + ERR_W'({run_q, 1'b0});
		end
	end

	assign stat.at_end   = (major_q == major_end_q);
	assign stat.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_q     <= '0;
			minor_q     <= '0;
			major_end_q <= '0;
			run_q       <= '0;
			rise_q      <= '0;
			err_q       <= '0;
			down_q      <= 1'b0;
			swap_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				major_q     <= a0;
				minor_q     <= b0;
				major_end_q <= a1;
				run_q       <= a1 - a0;
				rise_q      <= (b1 > b0) ? b1 - b0 : b0 - b1;
				err_q       <= ERR_W'(a1 - a0);
				down_q      <= !(b0 < b1);
				swap_q      <= swap;
			end else if (cmd.step) begin
				major_q <= major_q + 1'b1;
				minor_q <= minor_nxt;
				err_q   <= err_nxt;
			end
			if (cmd.step) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// output payload, loaded only when a new point is issued
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			point_x_q <= swap_q ? minor_q : major_q;
			point_y_q <= swap_q ? major_q : minor_q;
			last_q    <= (major_q + 1'b1) == major_end_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign point_x    = point_x_q;
	assign point_y    = point_y_q;
	assign last_point = last_q;

endmodule

// ===== tb/bresenham_line_stepper_test.sv =====
// Self-checking testbench for the Bresenham line stepper: random and directed lines.
module bresenham_line_stepper_test
	import bls_pkg::*;
;

	localparam int IMAGE_SIDE = 64;
	localparam int DRAIN_CYCLES = 80;
	localparam longint RUN_LIMIT = 64'd10_000_000;

	typedef struct {
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		int     gap_after;
		bit     drain_first;
	} line_req_t;

	typedef struct {
		coord_t x;
		coord_t y;
		logic   last;
	} line_point_t;

	logic   clk;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	coord_t start_x = '0;
	coord_t start_y = '0;
	coord_t end_x = '0;
	coord_t end_y = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	coord_t point_x;
	coord_t point_y;
	logic   last_point;

	line_req_t   line_queue[$];
	line_point_t plotted_points[$];
	line_req_t   cur_req;
	line_point_t want;

	int lines_total = 0;
	int lines_accepted = 0;
	int points_checked = 0;
	int steep_lines = 0;
	int empty_lines = 0;
	int mismatches = 0;
	int send_idle = 0;
	int recv_hold = 0;
	int hold_draw;

	bresenham_line_stepper #(
		.IMAGE_SIDE(IMAGE_SIDE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.point_x(point_x),
		.point_y(point_y),
		.last_point(last_point)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int sat_coord(coord_t v);
		return (int'(v) > IMAGE_SIDE - 1) ? IMAGE_SIDE - 1 : int'(v);
	endfunction

	function automatic int abs_diff(int a, int b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Expected raster points of one line, doubled integer error term.
	task automatic plot_line(input coord_t sx, input coord_t sy, input coord_t ex,
		input coord_t ey);
		int x0, y0, x1, y1, a0, b0, a1, b1, t, run, rise, err, b;
		bit steep, down;
		line_point_t pt;
		x0 = sat_coord(sx);
		y0 = sat_coord(sy);
		x1 = sat_coord(ex);
		y1 = sat_coord(ey);
		steep = abs_diff(y1, y0) > abs_diff(x1, x0);
		if (steep) begin
			a0 = y0; b0 = x0; a1 = y1; b1 = x1;
		end else begin
			a0 = x0; b0 = y0; a1 = x1; b1 = y1;
		end
		if (a0 > a1) begin
			t = a0; a0 = a1; a1 = t;
			t = b0; b0 = b1; b1 = t;
		end
		run = a1 - a0;
		rise = abs_diff(b1, b0);
		down = !(b0 < b1);
		err = run;
		b = b0;
		for (int a = a0; a < a1; a++) begin
			pt.x = coord_t'(steep ? b : a);
			pt.y = coord_t'(steep ? a : b);
			pt.last = (a + 1 == a1);
			plotted_points = {plotted_points, pt};
			err -= 2 * rise;
			if (err < 0) begin
				b += down ? -1 : 1;
				err += 2 * run;
			end
		end
		if (steep)
			steep_lines++;
		if (run == 0)
			empty_lines++;
	endtask

	task automatic add_line(input int sx, input int sy, input int ex, input int ey,
		input int gap, input bit drain);
		line_req_t r;
		r.sx = coord_t'(sx);
		r.sy = coord_t'(sy);
		r.ex = coord_t'(ex);
		r.ey = coord_t'(ey);
		r.gap_after = gap;
		r.drain_first = drain;
		line_queue = {line_queue, r};
	endtask

	function automatic int near_coord(int base, int reach);
		int v;
		v = base + $urandom_range(0, 2 * reach) - reach;
		if (v < 0)
			v = 0;
		if (v > IMAGE_SIDE - 1)
			v = IMAGE_SIDE - 1;
		return v;
	endfunction

	function automatic int edge_coord();
		return $urandom_range(0, 1) ? IMAGE_SIDE - 1 : 0;
	endfunction

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			start_x <= '0;
			start_y <= '0;
			end_x <= '0;
			end_y <= '0;
			send_idle <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				plot_line(start_x, start_y, end_x, end_y);
				lines_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (send_idle != 0) begin
					in_valid <= 1'b0;
					send_idle <= send_idle - 1;
				end else if (line_queue.size() != 0 &&
					!(line_queue[0].drain_first && plotted_points.size() != 0)) begin
					cur_req = line_queue.pop_front();
					start_x <= cur_req.sx;
					start_y <= cur_req.sy;
					end_x <= cur_req.ex;
					end_y <= cur_req.ey;
					in_valid <= 1'b1;
					send_idle <= cur_req.gap_after;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Point monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_hold <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (plotted_points.size() == 0) begin
					$error("unexpected point x=%0d y=%0d last=%0b", point_x, point_y,
						last_point);
					mismatches++;
				end else begin
					want = plotted_points.pop_front();
					if (point_x !== want.x) begin
						$error("point_x expected %0d actual %0d", want.x, point_x);
						mismatches++;
					end
					if (point_y !== want.y) begin
						$error("point_y expected %0d actual %0d", want.y, point_y);
						mismatches++;
					end
					if (last_point !== want.last) begin
						$error("last_point expected %0b actual %0b", want.last, last_point);
						mismatches++;
					end
				end
				points_checked++;
				// every fourth stretch of 256 points runs without back-pressure
				hold_draw = (((points_checked / 256) % 4) == 3) ? 0 : $urandom_range(0, 8);
				recv_hold <= hold_draw;
				out_stall <= (hold_draw != 0);
			end else if (recv_hold > 1) begin
				recv_hold <= recv_hold - 1;
			end else begin
				recv_hold <= 0;
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int pick, bx, by;
		// directed lines
		add_line(0, 0, 0, 0, 0, 0);
		add_line(63, 63, 63, 63, 0, 0);
		add_line(0, 5, 63, 5, 2, 0);
		add_line(63, 58, 0, 58, 0, 0);
		add_line(10, 0, 10, 63, 0, 0);
		add_line(53, 63, 53, 0, 3, 0);
		add_line(0, 0, 63, 63, 0, 1);
		add_line(0, 63, 63, 0, 0, 0);
		add_line(63, 0, 0, 63, 0, 0);
		add_line(3, 60, 5, 1, 1, 0);
		add_line(60, 2, 1, 9, 0, 0);
		add_line(0, 0, 1, 0, 0, 0);
		add_line(0, 0, 1, 1, 0, 0);
		add_line(5, 5, 5, 6, 0, 0);
		add_line(7, 7, 7, 7, 0, 0);
		add_line(20, 30, 40, 20, 0, 0);
		add_line(40, 20, 20, 30, 0, 1);
		add_line(12, 50, 14, 10, 0, 0);
		add_line(63, 0, 0, 0, 0, 0);
		add_line(0, 63, 63, 62, 4, 0);
		// random lines: mostly short ones, some full-range, some on the border
		for (int i = 0; i < 300; i++) begin
			line_req_t r;
			pick = $urandom_range(0, 9);
			bx = $urandom_range(0, IMAGE_SIDE - 1);
			by = $urandom_range(0, IMAGE_SIDE - 1);
			if (pick < 6) begin
				r.sx = coord_t'(bx);
				r.sy = coord_t'(by);
				r.ex = coord_t'(near_coord(bx, 8));
				r.ey = coord_t'(near_coord(by, 8));
			end else if (pick < 9) begin
				r.sx = coord_t'($urandom);
				r.sy = coord_t'($urandom);
				r.ex = coord_t'($urandom);
				r.ey = coord_t'($urandom);
			end else begin
				r.sx = coord_t'(edge_coord());
				r.sy = coord_t'(edge_coord());
				r.ex = coord_t'($urandom_range(0, 1) ? edge_coord() : bx);
				r.ey = coord_t'($urandom_range(0, 1) ? edge_coord() : by);
			end
			r.gap_after = (i >= 100 && i < 150) ? 0 : $urandom_range(0, 8);
			r.drain_first = ($urandom_range(0, 19) == 0);
			line_queue = {line_queue, r};
		end
		lines_total = line_queue.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (lines_accepted < lines_total)
			@(posedge clk);
		while (plotted_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("lines sent %0d (steep %0d, zero length %0d), points checked %0d",
			lines_accepted, steep_lines, empty_lines, points_checked);
		$display("stalls and gaps of 0..8 cycles on both sides, plus drained restarts");
		if (mismatches == 0 && plotted_points.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
